FILE: rtl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared constants, request and status codes and the result word type for
// the two-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 16;
    localparam int REQ_W     = 2;
    localparam int ST_W      = 2;
    localparam int FILL_W    = 5;

    localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PRIO = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RSVD = 2'd3;

    localparam logic [ST_W-1:0] ST_PUSHED = 2'd0;
    localparam logic [ST_W-1:0] ST_POPPED = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    localparam logic signed [DATA_W-1:0] THRESH_RESET = 16'sd60;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        data_t             pop_value;
        logic [FILL_W-1:0] fill;
    } result_t;

endpackage

FILE: rtl/tcpq_mem.sv
// ----------------------------------------------------------------------------
// tcpq_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcpq_mem
    import tcpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  data_t            wdata,
    input  logic [IDX_W-1:0] raddr,
    output data_t            rdata
);

    data_t mem [DEPTH];
    data_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tcpq_ctrl.sv
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Sequencer of the queue: circular head pointer and count, one shared
// threshold comparator, and a forward insertion pass that carries each
// displaced entry one slot toward the tail.
// ----------------------------------------------------------------------------
module tcpq_ctrl
    import tcpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [REQ_W-1:0] req_type,
    input  data_t            push_value,
    input  data_t            threshold,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res,
    output logic             mem_we,
    output logic [IDX_W-1:0] mem_waddr,
    output data_t            mem_wdata,
    output logic [IDX_W-1:0] mem_raddr,
    input  data_t            mem_rdata
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_POP_RD = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic             inserted_reg, inserted_next;
    data_t            value_reg, value_next;
    data_t            carry_reg, carry_next;
    logic [ST_W-1:0]  status_reg, status_next;
    data_t            popv_reg, popv_next;

    data_t            cmp_a;
    logic             ge;
    logic             is_pop;
    logic             at_end;
    logic [CNT_W:0]   tail_sum;
    logic [IDX_W-1:0] tail_addr;

    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // shared comparator: request value when idle, stored entry during the pass
    assign cmp_a = (state_reg == S_SCAN) ? mem_rdata : push_value;
    assign ge    = (cmp_a >= threshold);

    assign is_pop   = req_type inside {REQ_POP, REQ_RSVD};
    assign at_end   = (step_reg == count_reg);
    assign tail_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign tail_addr = (tail_sum >= (CNT_W + 1)'(DEPTH))
                     ? IDX_W'(tail_sum - (CNT_W + 1)'(DEPTH))
                     : IDX_W'(tail_sum);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FINISH);
    assign res.status    = status_reg;
    assign res.pop_value = popv_reg;
    assign res.fill      = FILL_W'(count_reg);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        step_next     = step_reg;
        inserted_next = inserted_reg;
        value_next    = value_reg;
        carry_next    = carry_reg;
        status_next   = status_reg;
        popv_next     = popv_reg;
        mem_we        = 1'b0;
        mem_waddr     = ptr_reg;
        mem_wdata     = value_reg;
        mem_raddr     = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    value_next = push_value;
                    popv_next  = '0;
                    if (is_pop)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            // head read issued this cycle
                            state_next = S_POP_RD;
                        end
                    end
                    else if (count_reg == CNT_W'(DEPTH))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_FINISH;
                    end
                    else if (req_type == REQ_PRIO && ge && count_reg != '0)
                    begin
                        ptr_next      = head_reg;
                        step_next     = '0;
                        inserted_next = 1'b0;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = tail_addr;
                        mem_wdata   = push_value;
                        count_next  = count_reg + 1'b1;
                        status_next = ST_PUSHED;
                        state_next  = S_FINISH;
                    end
                end
            end

            S_POP_RD:
            begin
                popv_next   = mem_rdata;
                head_next   = ptr_inc(head_reg);
                count_next  = count_reg - 1'b1;
                status_next = ST_POPPED;
                state_next  = S_FINISH;
            end

            S_SCAN:
            begin
                // read runs one slot ahead of the write
                mem_raddr = ptr_inc(ptr_reg);
                if (inserted_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = carry_reg;
                    carry_next = mem_rdata;
                end
                else if (at_end || !ge)
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = value_reg;
                    carry_next    = mem_rdata;
                    inserted_next = 1'b1;
                end
                if (at_end)
                begin
                    count_next  = count_reg + 1'b1;
                    status_next = ST_PUSHED;
                    state_next  = S_FINISH;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                    ptr_next  = ptr_inc(ptr_reg);
                end
            end

            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        step_reg     <= step_next;
        inserted_reg <= inserted_next;
        value_reg    <= value_next;
        carry_reg    <= carry_next;
        status_reg   <= status_next;
        popv_reg     <= popv_next;
    end

    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && !is_pop && count_reg == CNT_W'(DEPTH))
        |-> !mem_we)
        else $error("push written into a full queue");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP_RD) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not decrement the count");

    a_scan_end_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && at_end) |-> mem_we)
        else $error("insertion pass ended without a write");

    a_head_on_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_POP_RD) |=> (head_reg == $past(head_reg)))
        else $error("head moved outside a pop");

endmodule

FILE: rtl/two_class_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue_unit
// Bounded queue of signed 16-bit values with tail push, priority push and
// head pop; one result word per request word.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------
//   in       | in_valid / in_ready     | req_type, push_value
//   out      | out_valid / out_ready   | status, pop_value, fill_count
//   cfg      | cfg_wr_en               | cfg_wr_data (priority threshold)
//
// plain push, low-value priority push, full or empty: answered straight from idle
// pop: reads the head entry first; priority push of a high value with n
// entries held (n > 0): the single read port walks the store once;
// on an empty queue it takes the plain push path
// reset clears count and head pointer; stored entries are not cleared
// in_ready drops while a word is in work; results wait in an output register
// ----------------------------------------------------------------------------
module two_class_priority_queue_unit
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [REQ_W-1:0]         req_type,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ST_W-1:0]          status,
    output logic signed [DATA_W-1:0] pop_value,
    output logic [FILL_W-1:0]        fill_count,
    input  logic                     cfg_wr_en,
    input  logic signed [DATA_W-1:0] cfg_wr_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    data_t            thresh_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          res;
    logic             res_valid;
    logic             res_ready;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    data_t            mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    data_t            mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_wr_en)
        begin
            thresh_reg <= cfg_wr_data;
        end
    end

    tcpq_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .push_value (push_value),
        .threshold  (thresh_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    tcpq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output word register
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign pop_value  = out_reg.pop_value;
    assign fill_count = out_reg.fill;

endmodule
